@@ rtl/grt_pkg.sv @@
// Shared types and constants of the grid ray traversal block.
// No dependencies; used by grt_div, grt_sqrt and grid_ray_traversal.
package grt_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TILE_SIDE  = 2'd0;
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd1;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd2;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam int DIV_W   = 64;   // dividend and quotient bits
    localparam int DSR_W   = 32;   // divisor bits
    localparam int SQRT_IN = 64;
    localparam int SQRT_OUT = 32;

    localparam logic [31:0] STEP_SAT = 32'hFFFF_FFFF;
    localparam logic [23:0] OUT_SAT  = 24'hFF_FFFF;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DSR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               start;
        logic [SQRT_IN-1:0] radicand;
    } sqrt_req_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PX,
        ST_PY,
        ST_MAXD,
        ST_SQRT,
        ST_SX,
        ST_SY,
        ST_RX,
        ST_RY,
        ST_STEP,
        ST_BOUND,
        ST_RD,
        ST_HM,
        ST_OFF,
        ST_TP,
        ST_PIX,
        ST_OUT
    } state_t;

endpackage

@@ rtl/grt_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on grt_pkg (div_req_t, widths).
module grt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  grt_pkg::div_req_t         req,
    output logic                      done,
    output logic [grt_pkg::DIV_W-1:0] quot
);
    import grt_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
            dvd_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in where dividend bits shift out
            rem_next = ge ? DSR_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DSR_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

@@ rtl/grt_sqrt.sv @@
// Bit-pair integer square root, one result bit per cycle.
// Depends on grt_pkg (sqrt_req_t, widths).
module grt_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  grt_pkg::sqrt_req_t           req,
    output logic                         done,
    output logic [grt_pkg::SQRT_OUT-1:0] root
);
    import grt_pkg::*;

    localparam int CW = $clog2(SQRT_OUT);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SQRT_IN-1:0] v_reg, v_next;
    logic [SQRT_IN-1:0] r_reg, r_next;
    logic [SQRT_IN-1:0] b_reg, b_next;
    logic [SQRT_IN-1:0] trial;

    always_comb
    begin
        trial     = r_reg + b_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = req.radicand;
            r_next    = '0;
            b_next    = SQRT_IN'(1) << (SQRT_IN - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(SQRT_OUT - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[SQRT_OUT-1:0];

endmodule

@@ rtl/grid_ray_traversal.sv @@
// Tile-grid ray caster: wall bit map in a synchronous RAM, DDA walk sequencer.
// Depends on grt_pkg, grt_div and grt_sqrt.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tuser op, s_tdata cell/ray word
//  m_*      | out       | m_tvalid/m_tready  | m_tuser hit, m_tdata result word
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// After reset the map RAM is swept to zero; no words are taken meanwhile.
// A cast runs the shared serial divider for the start x and y and the range,
// then the square root, then the divider for the two step lengths; it then
// walks grid cells (step, bound check, RAM read), and on a hit divides twice
// more for the hit point. A result waits in the output register while the next
// word is taken; the sequencer stalls only while it is full and m_tready is low.
module grid_ray_traversal #(
    parameter int MAP_W = 64,
    parameter int MAP_H = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,      // op
    // cell_x[5:0] cell_y[11:6] wall_present[12] start_x[36:13] start_y[60:37]
    // dir_x[76:61] dir_y[92:77] max_range[116:93]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,      // hit
    // hit_cell_x[5:0] hit_cell_y[11:6] hit_pos_x[35:12] hit_pos_y[59:36]
    // distance[83:60]
    output logic [87:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    import grt_pkg::*;

    localparam int DEPTH = MAP_W * MAP_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    // configuration
    logic [8:0]  ts_reg;
    logic [6:0]  mw_reg, mh_reg;
    logic [8:0]  ts_eff;
    logic [10:0] mw_eff, mh_eff;

    // map RAM
    logic           mem [DEPTH];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic           mem_wdata;
    logic [AW-1:0]  mem_raddr;
    logic           rd_data_reg;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;

    // captured item
    logic        op_reg, op_next;
    logic [23:0] start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [15:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic [23:0] range_reg, range_next;

    // cast datapath
    logic [31:0]        px_reg, px_next, py_reg, py_next, maxd_reg, maxd_next;
    logic [31:0]        len_reg, len_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [34:0]        rx_reg, rx_next, ry_reg, ry_next, d_reg, d_next;
    logic signed [17:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [47:0]        prod_reg, prod_next, off_reg, off_next;
    logic signed [49:0] t_reg, t_next;
    logic [23:0]        pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic               hit_reg, hit_next, axis_reg, axis_next;
    logic               launched_reg, launched_next;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_tuser_reg, m_tuser_next;
    logic [87:0] m_tdata_reg, m_tdata_next;

    // helpers
    logic        s_acc, dx_neg, dy_neg, dir_zero, out_of_map, out_free;
    logic [15:0] ax, ay;
    logic [31:0] mag_sum;
    logic [16:0] fx_span, fy_span;
    logic [31:0] dc;
    logic [57:0] pix_prod;
    logic [23:0] pix_sat;
    logic [23:0] d_sat, maxd_sat;

    div_req_t           div_req;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    sqrt_req_t          sqrt_req;
    logic               sqrt_done;
    logic [SQRT_OUT-1:0] sqrt_root;

    grt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    grt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (ts_reg == 9'd0)
            ts_eff = 9'd1;
        else if (ts_reg > 9'd256)
            ts_eff = 9'd256;
        else
            ts_eff = ts_reg;
        if (mw_reg == 7'd0)
            mw_eff = 11'd1;
        else if ({4'b0, mw_reg} > 11'(MAP_W))
            mw_eff = 11'(MAP_W);
        else
            mw_eff = {4'b0, mw_reg};
        if (mh_reg == 7'd0)
            mh_eff = 11'd1;
        else if ({4'b0, mh_reg} > 11'(MAP_H))
            mh_eff = 11'(MAP_H);
        else
            mh_eff = {4'b0, mh_reg};
    end

    assign dx_neg   = dir_x_reg[15];
    assign dy_neg   = dir_y_reg[15];
    assign dir_zero = (dir_x_reg == 16'd0) && (dir_y_reg == 16'd0);
    assign ax       = dx_neg ? 16'(-dir_x_reg) : dir_x_reg;
    assign ay       = dy_neg ? 16'(-dir_y_reg) : dir_y_reg;
    // at most 2 x 2^30, fits 32 bits
    assign mag_sum  = 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay);
    assign fx_span  = dx_neg ? {1'b0, px_reg[15:0]} : 17'h10000 - {1'b0, px_reg[15:0]};
    assign fy_span  = dy_neg ? {1'b0, py_reg[15:0]} : 17'h10000 - {1'b0, py_reg[15:0]};
    assign dc       = (d_reg[34:32] != 3'd0) ? STEP_SAT : d_reg[31:0];
    assign pix_prod = 58'(t_reg[48:0]) * 58'(ts_eff);
    assign pix_sat  = (pix_prod[57:32] != '0) ? OUT_SAT : pix_prod[31:8];
    assign d_sat    = (d_reg[34:24] != '0) ? OUT_SAT : d_reg[23:0];
    assign maxd_sat = (maxd_reg[31:24] != '0) ? OUT_SAT : maxd_reg[23:0];

    assign out_of_map = (cx_reg < 18'sd0) || (cx_reg >= $signed({7'b0, mw_eff}))
                     || (cy_reg < 18'sd0) || (cy_reg >= $signed({7'b0, mh_eff}));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (s_acc)
                    state_next = (s_tuser == OP_CAST) ? ST_PX : ST_OUT;
            end
            ST_PX:   if (div_done) state_next = ST_PY;
            ST_PY:   if (div_done) state_next = ST_MAXD;
            ST_MAXD: if (div_done) state_next = dir_zero ? ST_OUT : ST_SQRT;
            ST_SQRT: if (sqrt_done) state_next = ST_SX;
            ST_SX:   if (ax == 16'd0 || div_done) state_next = ST_SY;
            ST_SY:   if (ay == 16'd0 || div_done) state_next = ST_RX;
            ST_RX:   state_next = ST_RY;
            ST_RY:   state_next = (maxd_reg != 32'd0) ? ST_STEP : ST_OUT;
            ST_STEP: state_next = ST_BOUND;
            ST_BOUND: state_next = out_of_map ? ST_OUT : ST_RD;
            ST_RD:
            begin
                if (rd_data_reg)
                    state_next = ST_HM;
                else if (d_reg < {3'b0, maxd_reg})
                    state_next = ST_STEP;
                else
                    state_next = ST_OUT;
            end
            ST_HM:   state_next = ST_OFF;
            ST_OFF:  if (div_done) state_next = ST_TP;
            ST_TP:   state_next = ST_PIX;
            ST_PIX:  state_next = axis_reg ? ST_OUT : ST_HM;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        op_next      = op_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        range_next   = range_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        maxd_next    = maxd_reg;
        len_next     = len_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        d_next       = d_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        prod_next    = prod_reg;
        off_next     = off_reg;
        t_next       = t_reg;
        pix_x_next   = pix_x_reg;
        pix_y_next   = pix_y_reg;
        hit_next     = hit_reg;
        axis_next    = axis_reg;
        clr_cnt_next = clr_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tuser_next  = m_tuser_reg;
        m_tdata_next  = m_tdata_reg;

        div_req.start     = 1'b0;
        div_req.dividend  = {DIV_W{1'b0}};
        div_req.divisor   = 32'(ts_eff);
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = {mag_sum, 32'd0};
        mem_we    = 1'b0;
        mem_waddr = AW'(AW'(s_tdata[11:6]) * AW'(MAP_W) + AW'(s_tdata[5:0]));
        mem_wdata = s_tdata[12];
        mem_raddr = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    op_next      = s_tuser;
                    start_x_next = s_tdata[36:13];
                    start_y_next = s_tdata[60:37];
                    dir_x_next   = s_tdata[76:61];
                    dir_y_next   = s_tdata[92:77];
                    range_next   = s_tdata[116:93];
                    hit_next     = 1'b0;
                    axis_next    = 1'b0;
                    if (s_tuser == OP_WRITE && 32'(s_tdata[5:0]) < 32'(MAP_W)
                        && 32'(s_tdata[11:6]) < 32'(MAP_H))
                        mem_we = 1'b1;
                end
            end
            ST_PX:
            begin
                div_req.start    = !launched_reg;
                div_req.dividend = DIV_W'({start_x_reg, 8'd0});
                if (div_done)
                    px_next = div_quot[31:0];
            end
            ST_PY:
            begin
                div_req.start    = !launched_reg;
                div_req.dividend = DIV_W'({start_y_reg, 8'd0});
                if (div_done)
                    py_next = div_quot[31:0];
            end
            ST_MAXD:
            begin
                div_req.start    = !launched_reg;
                div_req.dividend = DIV_W'({range_reg, 8'd0});
                if (div_done)
                    maxd_next = div_quot[31:0];
            end
            ST_SQRT:
            begin
                sqrt_req.start = !launched_reg;
                if (sqrt_done)
                    len_next = sqrt_root;
            end
            ST_SX:
            begin
                div_req.dividend = DIV_W'({len_reg, 16'd0});
                div_req.divisor  = 32'(ax);
                if (ax == 16'd0)
                    sx_next = STEP_SAT;
                else
                begin
                    div_req.start = !launched_reg;
                    if (div_done)
                        sx_next = (div_quot[63:32] != '0) ? STEP_SAT : div_quot[31:0];
                end
            end
            ST_SY:
            begin
                div_req.dividend = DIV_W'({len_reg, 16'd0});
                div_req.divisor  = 32'(ay);
                if (ay == 16'd0)
                    sy_next = STEP_SAT;
                else
                begin
                    div_req.start = !launched_reg;
                    if (div_done)
                        sy_next = (div_quot[63:32] != '0) ? STEP_SAT : div_quot[31:0];
                end
            end
            ST_RX:
            begin
                rx_next = 35'((49'(fx_span) * 49'(sx_reg)) >> 16);
                cx_next = $signed({2'b0, px_reg[31:16]});
                cy_next = $signed({2'b0, py_reg[31:16]});
                d_next  = '0;
            end
            ST_RY:
            begin
                ry_next = 35'((49'(fy_span) * 49'(sy_reg)) >> 16);
            end
            ST_STEP:
            begin
                // tie goes to y
                if (rx_reg < ry_reg)
                begin
                    cx_next = dx_neg ? cx_reg - 18'sd1 : cx_reg + 18'sd1;
                    d_next  = rx_reg;
                    rx_next = rx_reg + {3'b0, sx_reg};
                end
                else
                begin
                    cy_next = dy_neg ? cy_reg - 18'sd1 : cy_reg + 18'sd1;
                    d_next  = ry_reg;
                    ry_next = ry_reg + {3'b0, sy_reg};
                end
            end
            ST_BOUND:
            begin
                if (!out_of_map)
                    mem_raddr = AW'(AW'(cy_reg[16:0]) * AW'(MAP_W) + AW'(cx_reg[16:0]));
            end
            ST_RD:
            begin
                if (rd_data_reg)
                    hit_next = 1'b1;
            end
            ST_HM:
            begin
                prod_next = 48'(dc) * 48'(axis_reg ? ay : ax);
            end
            ST_OFF:
            begin
                div_req.start    = !launched_reg;
                div_req.dividend = {prod_reg, 16'd0};
                div_req.divisor  = len_reg;
                if (div_done)
                    off_next = div_quot[47:0];
            end
            ST_TP:
            begin
                if (axis_reg ? dy_neg : dx_neg)
                    t_next = $signed({18'd0, axis_reg ? py_reg : px_reg})
                           - $signed({2'b0, off_reg});
                else
                    t_next = $signed({18'd0, axis_reg ? py_reg : px_reg})
                           + $signed({2'b0, off_reg});
            end
            ST_PIX:
            begin
                if (axis_reg)
                    pix_y_next = (t_reg < 50'sd0) ? 24'd0 : pix_sat;
                else
                    pix_x_next = (t_reg < 50'sd0) ? 24'd0 : pix_sat;
                axis_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_reg;
                    if (hit_reg)
                        m_tdata_next = {4'd0, d_sat, pix_y_reg, pix_x_reg,
                                        cy_reg[5:0], cx_reg[5:0]};
                    else if (op_reg == OP_CAST)
                        m_tdata_next = {4'd0, maxd_sat, 60'd0};
                    else
                        m_tdata_next = '0;
                end
            end
            default: ;
        endcase

        if (div_done || sqrt_done)
            launched_next = 1'b0;
        else if (div_req.start || sqrt_req.start)
            launched_next = 1'b1;
        else
            launched_next = launched_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            launched_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ts_reg       <= 9'd16;
            mw_reg       <= 7'd64;
            mh_reg       <= 7'd64;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            launched_reg <= launched_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TILE_SIDE:  ts_reg <= cfg_data;
                    REG_MAP_WIDTH:  mw_reg <= cfg_data[6:0];
                    REG_MAP_HEIGHT: mh_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        start_x_reg <= start_x_next;
        start_y_reg <= start_y_next;
        dir_x_reg   <= dir_x_next;
        dir_y_reg   <= dir_y_next;
        range_reg   <= range_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        maxd_reg    <= maxd_next;
        len_reg     <= len_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        d_reg       <= d_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        prod_reg    <= prod_next;
        off_reg     <= off_next;
        t_reg       <= t_next;
        pix_x_reg   <= pix_x_next;
        pix_y_reg   <= pix_y_next;
        hit_reg     <= hit_next;
        axis_reg    <= axis_next;
        m_tuser_reg <= m_tuser_next;
        m_tdata_reg <= m_tdata_next;
    end

    // map RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

`ifndef SYNTHESIS
    a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_PX || state_reg == ST_PY || state_reg == ST_MAXD
                      || state_reg == ST_SX || state_reg == ST_SY || state_reg == ST_OFF))
        else $error("divider result outside a divide state");
    a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == ST_SQRT)
        else $error("square root result outside its state");
    a_ram_write_when: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("map write during a cast");
    a_word_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != ST_IDLE)
        else $error("accepted word not processed");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for grid_ray_traversal: wall writes and ray casts in.
// Depends on grt_pkg and the grid_ray_traversal RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import grt_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] travel;
    } ray_result_t;

    typedef struct packed {
        logic         op;
        logic [119:0] word;
    } ray_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic         s_tuser;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         m_tuser;
    logic [87:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [8:0]   cfg_data;

    grid_ray_traversal DUT (.*);

    // predictor state
    bit          wall_bits [4096];
    logic [8:0]  tile_reg;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;

    ray_item_t   pending_items [$];
    ray_result_t expected_results [$];
    int          errors;
    int          casts_sent;
    int          hits_seen;
    int          words_checked;
    int          gap_left;
    int          stall_left;
    bit          no_idle;
    bit          stim_done;
    bit          in_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned clamp_reg(longint unsigned v, longint unsigned hi);
        if (v < 1)
            return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic longint unsigned sat24(longint unsigned v);
        return v > 64'hFF_FFFF ? 64'hFF_FFFF : v;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned step_len(longint unsigned len, longint unsigned mag);
        longint unsigned s;
        if (mag == 0)
            return 64'hFFFF_FFFF;
        s = (len << 16) / mag;
        return s > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : s;
    endfunction

    function automatic logic [23:0] hit_pixel(longint pos, bit neg, longint unsigned d,
                                              longint unsigned mag, longint unsigned len,
                                              longint unsigned ts);
        longint unsigned dc;
        longint off;
        longint t;
        dc = d > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : d;
        off = longint'(((dc * mag) << 16) / len);
        t = neg ? pos - off : pos + off;
        if (t < 0)
            return 24'd0;
        return sat24((longint'(t) * ts) >> 8);
    endfunction

    function automatic ray_result_t trace_ray(logic [119:0] w);
        ray_result_t     r;
        longint unsigned ts, mw, mh, maxd, len, sx, sy, rx, ry, d, fx, fy, ax, ay;
        longint          px, py, cx, cy;
        int              dx, dy;
        bit              found;
        r = '0;
        found = 0;
        ts = clamp_reg(tile_reg, 256);
        mw = clamp_reg(width_reg, 64);
        mh = clamp_reg(height_reg, 64);
        px = longint'((u64_t'(w[36:13]) << 8) / ts);
        py = longint'((u64_t'(w[60:37]) << 8) / ts);
        dx = $signed(w[76:61]);
        dy = $signed(w[92:77]);
        maxd = (u64_t'(w[116:93]) << 8) / ts;
        r.travel = sat24(maxd);
        if (dx == 0 && dy == 0)
            return r;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        len = root64((ax * ax + ay * ay) << 32);
        sx = step_len(len, ax);
        sy = step_len(len, ay);
        cx = px >>> 16;
        cy = py >>> 16;
        fx = px & 64'hFFFF;
        fy = py & 64'hFFFF;
        rx = ((dx < 0 ? fx : 65536 - fx) * sx) >> 16;
        ry = ((dy < 0 ? fy : 65536 - fy) * sy) >> 16;
        d = 0;
        while (d < maxd)
        begin
            if (rx < ry)
            begin
                cx += dx < 0 ? -1 : 1;
                d = rx;
                rx += sx;
            end
            else
            begin
                cy += dy < 0 ? -1 : 1;
                d = ry;
                ry += sy;
            end
            if (cx < 0 || cx >= longint'(mw) || cy < 0 || cy >= longint'(mh))
                break;
            if (wall_bits[cy * 64 + cx])
            begin
                found = 1;
                break;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            r.cell_x = cx[5:0];
            r.cell_y = cy[5:0];
            r.pos_x = hit_pixel(px, dx < 0, d, ax, len, ts);
            r.pos_y = hit_pixel(py, dy < 0, d, ay, len, ts);
            r.travel = sat24(d);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void queue_item(ray_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void expect_result(ray_result_t r);
        expected_results = {expected_results, r};
    endfunction

    // marks a word taken at the last rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    // acceptance, prediction and checking on the rising edge
    always @(posedge clk)
    begin
        ray_result_t got, want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TILE_SIDE)
                    tile_reg <= cfg_data;
                else if (cfg_index == REG_MAP_WIDTH)
                    width_reg <= cfg_data[6:0];
                else if (cfg_index == REG_MAP_HEIGHT)
                    height_reg <= cfg_data[6:0];
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_WRITE)
                begin
                    wall_bits[s_tdata[11:6] * 64 + s_tdata[5:0]] = s_tdata[12];
                    expect_result('0);
                end
                else
                    expect_result(trace_ray(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[5:0], m_tdata[11:6], m_tdata[35:12],
                       m_tdata[59:36], m_tdata[83:60]};
                words_checked++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected word", got, 0);
                else
                begin
                    want = expected_results.pop_front();
                    hits_seen += want.hit;
                    if (got.hit != want.hit)
                        report_mismatch("hit", got.hit, want.hit);
                    if (got.cell_x != want.cell_x)
                        report_mismatch("hit_cell_x", got.cell_x, want.cell_x);
                    if (got.cell_y != want.cell_y)
                        report_mismatch("hit_cell_y", got.cell_y, want.cell_y);
                    if (got.pos_x != want.pos_x)
                        report_mismatch("hit_pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y != want.pos_y)
                        report_mismatch("hit_pos_y", got.pos_y, want.pos_y);
                    if (got.travel != want.travel)
                        report_mismatch("distance", got.travel, want.travel);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // input driver: changes on the falling edge
    always @(negedge clk)
    begin
        ray_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else if (!s_tvalid || in_taken)
        begin
            // the word on the bus went at the last rising edge
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                s_tuser <= it.op;
                s_tdata <= it.word;
                s_tvalid <= 1'b1;
                gap_left = pick_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result stall pattern
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    function automatic ray_item_t wall_item(int x, int y, bit wall);
        ray_item_t it;
        it = '0;
        it.op = OP_WRITE;
        it.word[5:0] = x;
        it.word[11:6] = y;
        it.word[12] = wall;
        // unused bits carry noise
        it.word[116:13] = {$urandom, $urandom, $urandom, $urandom};
        return it;
    endfunction

    function automatic ray_item_t cast_item(logic [23:0] sx, logic [23:0] sy,
                                            logic [15:0] dx, logic [15:0] dy,
                                            logic [23:0] range);
        ray_item_t it;
        it = '0;
        it.op = OP_CAST;
        it.word[12:0] = $urandom;
        it.word[36:13] = sx;
        it.word[60:37] = sy;
        it.word[76:61] = dx;
        it.word[92:77] = dy;
        it.word[116:93] = range;
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int ts, mw, mh, span_x, span_y, kind;
        logic [15:0] dx, dy;
        logic [23:0] sx, sy, rng;
        ts = clamp_reg(tile_reg, 256);
        mw = clamp_reg(width_reg, 64);
        mh = clamp_reg(height_reg, 64);
        span_x = mw * ts * 256;
        span_y = mh * ts * 256;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // mostly inside the map in use, a few anywhere
                if ($urandom_range(0, 9) < 8)
                    queue_item(wall_item($urandom_range(0, mw - 1),
                        $urandom_range(0, mh - 1), $urandom_range(0, 9) < 6));
                else
                    queue_item(wall_item($urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 1)));
            end
            else
            begin
                casts_sent++;
                if ($urandom_range(0, 9) < 8)
                begin
                    sx = $urandom_range(0, span_x - 1);
                    sy = $urandom_range(0, span_y - 1);
                end
                else
                begin
                    sx = $urandom;
                    sy = $urandom;
                end
                dx = $urandom;
                dy = $urandom;
                case ($urandom_range(0, 9))
                    0: dx = '0;
                    1: dy = '0;
                    2: begin dx = $urandom_range(0, 7) - 4; dy = $urandom_range(0, 7) - 4; end
                    default: ;
                endcase
                if ($urandom_range(0, 9) < 7)
                    rng = $urandom_range(0, 2 * (span_x > span_y ? span_x : span_y));
                else
                    rng = $urandom;
                queue_item(cast_item(sx, sy, dx, dy, rng));
            end
        end
    endtask

    initial
    begin
        logic [8:0] phase_cfg [7][3];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_TILE_SIDE;
        cfg_data = '0;
        tile_reg = 9'd16;
        width_reg = 7'd64;
        height_reg = 7'd64;
        errors = 0;
        casts_sent = 0;
        hits_seen = 0;
        words_checked = 0;
        stall_left = 0;
        no_idle = 0;
        stim_done = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, 16 px tiles, 64 x 64 map
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd100, 16'sd0,
                             24'hFF_FFFF));
        queue_item(wall_item(10, 1, 1));
        queue_item(wall_item(1, 10, 1));
        queue_item(wall_item(63, 63, 1));
        queue_item(wall_item(0, 0, 1));
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd100, 16'sd0,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd0, 16'sd7,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd0, 16'sd0,
                             24'h12_3456));
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd100, 16'sd0,
                             24'h00_0000));
        // diagonal tie from a tile center, then negative directions
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd1, 16'sd1,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h3F_8000, 24'h3F_8000, 16'h8000, 16'h8000,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h3F_8000, 24'h3F_8000, 16'h7FFF, 16'h7FFF,
                             24'hFF_FFFF));
        queue_item(cast_item(24'hFF_FFFF, 24'hFF_FFFF, 16'h8000, 16'h7FFF,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h00_0000, 24'h00_0000, 16'h7FFF, 16'h8000,
                             24'hFF_FFFF));
        queue_item(cast_item(24'h00_0000, 24'h00_0000, 16'h0001, 16'hFFFF,
                             24'h00_2000));
        queue_item(wall_item(10, 1, 0));
        queue_item(cast_item(24'h00_1800, 24'h00_1800, 16'sd100, 16'sd0,
                             24'h00_9000));
        queue_item(cast_item(24'h01_0000, 24'h00_1800, 16'hFF00, 16'sd0,
                             24'hFF_FFFF));
        drain();

        phase_cfg = '{'{9'd1, 9'd64, 9'd64}, '{9'd256, 9'd8, 9'd8},
                      '{9'd0, 9'd0, 9'd0}, '{9'd511, 9'd127, 9'd127},
                      '{9'd37, 9'd20, 9'd45}, '{9'd3, 9'd64, 9'd1},
                      '{9'd16, 9'h180, 9'h1BF}};
        for (int p = 0; p < 7; p++)
        begin
            write_reg(REG_TILE_SIDE, phase_cfg[p][0]);
            write_reg(REG_MAP_WIDTH, phase_cfg[p][1]);
            write_reg(REG_MAP_HEIGHT, phase_cfg[p][2]);
            @(posedge clk);
            no_idle = (p % 3 == 1);
            random_phase(270);
            // sender holds off until every result of the phase is back
            drain();
        end
        stim_done = 1;
        repeat (50) @(posedge clk);
        $display("covered %0d checked words, %0d casts, %0d wall hits over 8 register settings",
                 words_checked, casts_sent + 13, hits_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("timeout with %0d words outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
